FILE: rtl/core/pfc_pkg.sv
package pfc_pkg;

   // Key square geometry and the shape of the letter code.
   localparam int CELL_COUNT = 25;
   localparam int CODE_W = 5;
   localparam logic [CODE_W-1:0] MAX_CODE = 5'd24;
   localparam logic [CODE_W-1:0] CODE_X = 5'd22;
   localparam logic [CODE_W-1:0] FIRST_HIGH_CODE = 5'd9;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register file layout.
   localparam int CELLS_AB_W = 45;
   localparam int CELLS_C_W = 35;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 45;
   localparam logic [CELLS_AB_W-1:0] CELLS_A_RESET = 45'd9043225708576;
   localparam logic [CELLS_AB_W-1:0] CELLS_B_RESET = 45'd19258043411785;
   localparam logic [CELLS_C_W-1:0] CELLS_C_RESET = 35'd26565333618;

   // ASCII codes used by the character handling.
   localparam logic [7:0] ASCII_A = 8'h41;
   localparam logic [7:0] ASCII_I = 8'h49;
   localparam logic [7:0] ASCII_J = 8'h4A;
   localparam logic [7:0] ASCII_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] ASCII_NONE = 8'h00;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELLS_A,
      CSR_CELLS_B,
      CSR_CELLS_C,
      CSR_DECRYPT
   } csr_index_type;

   typedef logic [CELL_COUNT-1:0][CODE_W-1:0] square_type;

   typedef enum logic [1:0] {
      JOB_PAIR,
      JOB_ERROR,
      JOB_END
   } job_kind_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [CODE_W-1:0] pos_a;
      logic [CODE_W-1:0] pos_b;
      logic              decrypt;
      logic              last;
      logic              bad;
   } job_type;

   typedef struct packed {
      logic              found;
      logic [CODE_W-1:0] pos;
   } lookup_type;

   // First cell in row-major order that holds the code.
   function automatic lookup_type find_cell(input square_type sq,
                                            input logic [CODE_W-1:0] code);
      lookup_type r;
      r.found = 1'b0;
      r.pos = '0;
      for (int k = CELL_COUNT - 1; k >= 0; k--) begin
         if (sq[k] == code && code <= MAX_CODE) begin
            r.found = 1'b1;
            r.pos = CODE_W'(k);
         end
      end
      return r;
   endfunction

   // Uppercase letter other than J to its letter code.
   function automatic logic [CODE_W-1:0] ascii_code(input logic [7:0] u);
      logic [7:0] d;
      d = u - ASCII_A;
      if (u >= ASCII_J) begin
         d = d - 8'd1;
      end
      return d[CODE_W-1:0];
   endfunction

   function automatic logic [7:0] code_ascii(input logic [CODE_W-1:0] code);
      logic [7:0] a;
      if (code < FIRST_HIGH_CODE) begin
         a = ASCII_A + {3'b000, code};
      end else if (code <= MAX_CODE) begin
         a = ASCII_A + 8'd1 + {3'b000, code};
      end else begin
         a = ASCII_Z;
      end
      return a;
   endfunction

   function automatic logic [2:0] pos_row(input logic [CODE_W-1:0] pos);
      logic [2:0] r;
      if (pos >= 5'd20) begin
         r = 3'd4;
      end else if (pos >= 5'd15) begin
         r = 3'd3;
      end else if (pos >= 5'd10) begin
         r = 3'd2;
      end else if (pos >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] pos_col(input logic [CODE_W-1:0] pos);
      logic [CODE_W-1:0] base;
      logic [CODE_W-1:0] diff;
      base = {pos_row(pos), 2'b00} + {2'b00, pos_row(pos)};
      diff = pos - base;
      return diff[2:0];
   endfunction

   function automatic logic [CODE_W-1:0] pos_join(input logic [2:0] row,
                                                  input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   // One step around a row or column: forward to encrypt, back to decrypt.
   function automatic logic [2:0] advance(input logic [2:0] x, input logic decrypt);
      logic [2:0] y;
      if (!decrypt) begin
         y = (x == 3'd4) ? 3'd0 : x + 3'd1;
      end else begin
         y = (x == 3'd0) ? 3'd4 : x - 3'd1;
      end
      return y;
   endfunction

   // A pair becomes a substitution job, or an error when a letter is missing.
   function automatic job_type pair_job(input lookup_type a, input lookup_type b,
                                        input logic decrypt);
      job_type j;
      j.kind = (a.found && b.found) ? JOB_PAIR : JOB_ERROR;
      j.pos_a = a.pos;
      j.pos_b = b.pos;
      j.decrypt = decrypt;
      j.last = 1'b0;
      j.bad = 1'b0;
      return j;
   endfunction

endpackage

FILE: rtl/core/playfair_digraph_cipher_top.sv
// Playfair digraph cipher, one message byte per request.
// The request channel (req_valid/req_ready) carries a raw byte and a message
// end flag. The response channel (rsp_valid/rsp_ready) returns substituted
// letters, error markers and bare end markers; run_last marks the final
// response of each message. The csr channel writes the three key square
// registers and the decrypt mode and is always ready; the user writes it only
// while no message is in flight, which the block itself does not enforce.
// A front stage classifies each request, keeps the open pair and the error
// flag, looks both letters up in the square and pushes up to two jobs into
// a four-entry queue. A back stage turns each pair job into two letters,
// one per phase, and owns the response register.
// The first response of a request passes the queue, the job register and
// the response register before it shows on rsp_valid. The two letters of
// a pair share the response port one after the other, and a request that
// makes two pairs holds the request side while its second job is pushed.
// When the receiver stalls, the response register holds, the queue
// fills and req_ready drops; nothing is lost. Synchronous reset empties the
// queue, clears the open pair and error flag, and loads the default square.
module playfair_digraph_cipher_top
   import pfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_in,
   input  logic                   req_message_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_letter_out,
   output logic                   rsp_letter_valid,
   output logic                   rsp_bad_input,
   output logic                   rsp_run_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CELLS_AB_W-1:0] cells_a_ff;
   logic [CELLS_AB_W-1:0] cells_b_ff;
   logic [CELLS_C_W-1:0]  cells_c_ff;
   logic                  decrypt_ff;
   square_type            square;
   logic                  csr_write;

   logic                  q_push, q_pop, q_full, q_empty;
   job_type               q_push_job, q_head;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_a_ff <= CELLS_A_RESET;
         cells_b_ff <= CELLS_B_RESET;
         cells_c_ff <= CELLS_C_RESET;
         decrypt_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CELLS_A: cells_a_ff <= csr_wdata[CELLS_AB_W-1:0];
            CSR_CELLS_B: cells_b_ff <= csr_wdata[CELLS_AB_W-1:0];
            CSR_CELLS_C: cells_c_ff <= csr_wdata[CELLS_C_W-1:0];
            CSR_DECRYPT: decrypt_ff <= csr_wdata[0];
            default: decrypt_ff <= decrypt_ff;
         endcase
      end
   end

   // The three registers concatenate to the 25 cells in row-major order,
   // cell 0 in the low bits.
   assign square = {cells_c_ff, cells_b_ff, cells_a_ff};

   pfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_message_end (req_message_end),
      .square          (square),
      .decrypt         (decrypt_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_job      (q_push_job)
   );

   pfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   pfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .square           (square),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_letter_out   (rsp_letter_out),
      .rsp_letter_valid (rsp_letter_valid),
      .rsp_bad_input    (rsp_bad_input),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

FILE: rtl/core/pfc_front.sv
module pfc_front
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_message_end,
   input  square_type square,
   input  logic       decrypt,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_push_job
);

   logic [CODE_W-1:0] pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              err_ff, err_in;
   job_type           hold_ff, hold_in;
   logic              hold_valid_ff, hold_valid_in;

   logic [7:0]        upper;
   logic              enc_letter, dec_letter;
   logic [CODE_W-1:0] cur_code;
   lookup_type        lk_pend, lk_cur, lk_x;
   logic              accept;
   logic              a_on, b_on, b_kept, a_err;
   job_type           job_a, job_b, job_1, job_2, end_job;
   logic              j1_on, j2_on;

   // Character classification and the three square lookups.
   always_comb begin
      upper = req_char_in;
      if (req_char_in >= ASCII_LOWER_A && req_char_in <= ASCII_LOWER_Z) begin
         upper = req_char_in - CASE_OFFSET;
      end
      enc_letter = upper >= ASCII_A && upper <= ASCII_Z;
      dec_letter = req_char_in >= ASCII_A && req_char_in <= ASCII_Z && req_char_in != ASCII_J;
      if (decrypt) begin
         cur_code = ascii_code(req_char_in);
      end else begin
         cur_code = ascii_code((upper == ASCII_J) ? ASCII_I : upper);
      end
      lk_pend = find_cell(square, pend_ff);
      lk_cur = find_cell(square, cur_code);
      lk_x = find_cell(square, CODE_X);
   end

   assign accept = req_valid && req_ready;
   assign req_ready = !hold_valid_ff && !q_full;

   // Pairing rules: up to two jobs per request, a bare end marker included.
   always_comb begin
      a_on = 1'b0;
      b_on = 1'b0;
      job_a = pair_job(lk_pend, lk_cur, decrypt);
      job_b = pair_job(lk_pend, lk_x, decrypt);
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (!err_ff) begin
         if (!decrypt) begin
            if (enc_letter) begin
               if (!pend_valid_ff) begin
                  pend_in = cur_code;
                  pend_valid_in = 1'b1;
               end else if (pend_ff == cur_code) begin
                  a_on = 1'b1;
                  job_a = pair_job(lk_pend, lk_x, decrypt);
               end else begin
                  pend_valid_in = 1'b0;
                  a_on = 1'b1;
               end
            end
            if (req_message_end && pend_valid_in) begin
               pend_valid_in = 1'b0;
               b_on = 1'b1;
               if (enc_letter && !pend_valid_ff) begin
                  job_b = pair_job(lk_cur, lk_x, decrypt);
               end
            end
         end else begin
            if (dec_letter) begin
               if (pend_valid_ff) begin
                  pend_valid_in = 1'b0;
                  a_on = 1'b1;
               end else begin
                  pend_in = cur_code;
                  pend_valid_in = 1'b1;
               end
            end else begin
               pend_valid_in = 1'b0;
               a_on = 1'b1;
               job_a.kind = JOB_ERROR;
            end
            if (req_message_end && pend_valid_in) begin
               pend_valid_in = 1'b0;
               b_on = 1'b1;
               job_b.kind = JOB_ERROR;
            end
         end
      end

      // An error in the first pair silences the rest of the message.
      a_err = a_on && job_a.kind == JOB_ERROR;
      b_kept = b_on && !a_err;
      err_in = err_ff || a_err || (b_kept && job_b.kind == JOB_ERROR);

      end_job = job_a;
      end_job.kind = JOB_END;
      end_job.bad = err_ff;

      j1_on = a_on || b_kept || req_message_end;
      j2_on = a_on && b_kept;
      if (a_on) begin
         job_1 = job_a;
      end else if (b_kept) begin
         job_1 = job_b;
      end else begin
         job_1 = end_job;
      end
      job_1.last = req_message_end && !j2_on;
      job_2 = job_b;
      job_2.last = req_message_end;

      if (req_message_end) begin
         pend_in = '0;
         pend_valid_in = 1'b0;
         err_in = 1'b0;
      end
   end

   // The held second job goes out before the next request is taken.
   always_comb begin
      if (hold_valid_ff) begin
         q_push = !q_full;
         q_push_job = hold_ff;
         hold_valid_in = q_full;
         hold_in = hold_ff;
      end else begin
         q_push = accept && j1_on;
         q_push_job = job_1;
         hold_valid_in = accept && j2_on;
         hold_in = job_2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pend_valid_ff <= 1'b0;
         err_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_ff <= pend_in;
            pend_valid_ff <= pend_valid_in;
            err_ff <= err_in;
         end
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

FILE: rtl/core/pfc_queue.sv
module pfc_queue
   import pfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/core/pfc_back.sv
module pfc_back
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  square_type square,
   input  logic       q_empty,
   input  job_type    q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_letter_out,
   output logic       rsp_letter_valid,
   output logic       rsp_bad_input,
   output logic       rsp_run_last
);

   job_type           job_ff, job_in;
   logic              job_valid_ff, job_valid_in;
   logic              phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        letter_ff, letter_in;
   logic              lvalid_ff, lvalid_in;
   logic              bad_ff, bad_in;
   logic              last_ff, last_in;

   logic              out_free, emit, job_done;
   logic [2:0]        row_a, col_a, row_b, col_b;
   logic [CODE_W-1:0] out_a, out_b, out_pos;

   // Playfair substitution of the current pair.
   always_comb begin
      row_a = pos_row(job_ff.pos_a);
      col_a = pos_col(job_ff.pos_a);
      row_b = pos_row(job_ff.pos_b);
      col_b = pos_col(job_ff.pos_b);
      if (row_a == row_b) begin
         out_a = pos_join(row_a, advance(col_a, job_ff.decrypt));
         out_b = pos_join(row_b, advance(col_b, job_ff.decrypt));
      end else if (col_a == col_b) begin
         out_a = pos_join(advance(row_a, job_ff.decrypt), col_a);
         out_b = pos_join(advance(row_b, job_ff.decrypt), col_b);
      end else begin
         out_a = pos_join(row_a, col_b);
         out_b = pos_join(row_b, col_a);
      end
      out_pos = phase_ff ? out_b : out_a;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit = job_valid_ff && out_free;
   assign job_done = emit && (job_ff.kind != JOB_PAIR || phase_ff);
   assign q_pop = !q_empty && (!job_valid_ff || job_done);

   always_comb begin
      job_in = q_pop ? q_head : job_ff;
      job_valid_in = q_pop || (job_valid_ff && !job_done);
      phase_in = q_pop ? 1'b0 : (emit ? 1'b1 : phase_ff);
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      letter_in = ASCII_NONE;
      lvalid_in = 1'b0;
      bad_in = 1'b0;
      last_in = job_ff.last;
      unique case (job_ff.kind)
         JOB_PAIR: begin
            letter_in = code_ascii(square[out_pos]);
            lvalid_in = 1'b1;
            last_in = job_ff.last && phase_ff;
         end
         JOB_ERROR: begin
            bad_in = 1'b1;
         end
         JOB_END: begin
            bad_in = job_ff.bad;
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         letter_ff <= letter_in;
         lvalid_ff <= lvalid_in;
         bad_ff <= bad_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_letter_out = letter_ff;
   assign rsp_letter_valid = lvalid_ff;
   assign rsp_bad_input = bad_ff;
   assign rsp_run_last = last_ff;

`ifndef SYNTH
   a_second_half_is_pair: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && phase_ff |-> job_ff.kind == JOB_PAIR)
      else $error("second result phase on a job that is not a pair");
   a_letter_is_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && lvalid_ff |-> letter_ff >= ASCII_A && letter_ff <= ASCII_Z
         && letter_ff != ASCII_J)
      else $error("result letter outside the square alphabet");
   a_letter_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(lvalid_ff && bad_ff))
      else $error("letter result flagged as bad input");
`endif

endmodule
